@@ rtl/kbrkt_pkg.sv @@
package kbrkt_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int OUT_SLOTS = 6;
    localparam int CODE_W    = 8;
    localparam logic [CODE_W-1:0] MOD_MAX  = 8'd7;
    localparam logic [2:0]        MOD_MASK = 3'h7;

    typedef enum logic [1:0] {
        KIND_KEY_QUERY = 2'd0,
        KIND_KEY_SET   = 2'd1,
        KIND_MOD_QUERY = 2'd2,
        KIND_MOD_SET   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] code;
        logic              value;
    } t_req;

    typedef struct packed {
        logic              found;
        logic              status;
        logic [CODE_W-1:0] modifier_byte;
        logic [CODE_W-1:0] key_slot0;
        logic [CODE_W-1:0] key_slot1;
        logic [CODE_W-1:0] key_slot2;
        logic [CODE_W-1:0] key_slot3;
        logic [CODE_W-1:0] key_slot4;
        logic [CODE_W-1:0] key_slot5;
    } t_result;

    // broadcast to every slot cell
    typedef struct packed {
        logic              press;
        logic              release_key;
        logic [CODE_W-1:0] code;
    } t_cell_ctl;

    // carried from a cell to its right neighbor
    typedef struct packed {
        logic done;   // press already placed or found earlier
        logic hit;    // code matched at or before this cell
    } t_link;

endpackage

@@ rtl/kbrkt_cell.sv @@
module kbrkt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kbrkt_pkg::t_cell_ctl           i_ctl,
    input  kbrkt_pkg::t_link               i_link,
    output kbrkt_pkg::t_link               o_link,
    input  logic [kbrkt_pkg::CODE_W-1:0]   i_right,
    output logic [kbrkt_pkg::CODE_W-1:0]   o_slot,
    output logic [kbrkt_pkg::CODE_W-1:0]   o_slot_next
);

    logic [kbrkt_pkg::CODE_W-1:0] r_slot;
    logic [kbrkt_pkg::CODE_W-1:0] n_slot;
    logic                         w_empty;
    logic                         w_match;

    assign w_empty = (r_slot == '0);
    assign w_match = (r_slot == i_ctl.code);

    assign o_link.done = i_link.done | w_empty | w_match;
    assign o_link.hit  = i_link.hit | w_match;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.press && !i_link.done && w_empty) begin
            n_slot = i_ctl.code;
        end else if (i_ctl.release_key && (i_link.hit || w_match)) begin
            n_slot = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot      = r_slot;
    assign o_slot_next = n_slot;

endmodule

@@ rtl/keyboard_report_key_table_top.sv @@
// Keyboard report key table: one modifier byte plus a row of key slots kept
// packed to the front (zero marks an empty slot).
// Request channel: i_req (kind, code, value) is taken at a rising edge with
// start high and busy low. busy is always low, so one transaction can be
// issued every cycle.
// Result channel: o_valid pulses for one cycle, in the cycle after the request
// edge, with o_result holding found, status and the full report as it stands
// after that transaction. Throughput is 1 transaction per cycle; the slot
// cells resolve press placement and release shift-left in a single pass along
// the chain.
// The receiver cannot stall: each result is presented exactly once.
// A synchronous reset (i_rst_n low) empties every key slot, clears the
// modifier byte and drops o_valid.
// Modifier kinds with a bit number above 7 return status 1, found 0 and leave
// the report unchanged. Key kinds always return status 0.
module keyboard_report_key_table_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  kbrkt_pkg::t_req      i_req,
    output logic                 o_valid,
    output kbrkt_pkg::t_result   o_result
);

    localparam int N = kbrkt_pkg::KEY_SLOTS;
    localparam int W = kbrkt_pkg::CODE_W;

    kbrkt_pkg::t_cell_ctl w_ctl;
    kbrkt_pkg::t_link     w_link [N+1];
    logic [W-1:0]         w_slot [N];
    logic [W-1:0]         w_next [N];
    logic [W-1:0]         w_right [N];
    logic [W-1:0]         w_rep [kbrkt_pkg::OUT_SLOTS];

    logic [W-1:0]         r_mod;
    logic [W-1:0]         n_mod;
    logic                 r_valid;
    kbrkt_pkg::t_result   r_out;
    kbrkt_pkg::t_result   n_out;

    logic                 w_take;
    logic                 w_is_mod;
    logic                 w_bad_mod;
    logic [W-1:0]         w_bit;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_ctl.code        = i_req.code;
    assign w_ctl.press       = w_take && (i_req.kind == kbrkt_pkg::KIND_KEY_SET) &&
                               i_req.value;
    assign w_ctl.release_key = w_take && (i_req.kind == kbrkt_pkg::KIND_KEY_SET) &&
                               !i_req.value;

    assign w_link[0].done = 1'b0;
    assign w_link[0].hit  = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid
            assign w_right[g] = w_slot[g+1];
        end

        kbrkt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .i_right     (w_right[g]),
            .o_slot      (w_slot[g]),
            .o_slot_next (w_next[g])
        );
    end

    assign w_is_mod  = (i_req.kind == kbrkt_pkg::KIND_MOD_QUERY) ||
                       (i_req.kind == kbrkt_pkg::KIND_MOD_SET);
    assign w_bad_mod = w_is_mod && (i_req.code > kbrkt_pkg::MOD_MAX);
    assign w_bit     = W'(1) << (i_req.code[2:0] & kbrkt_pkg::MOD_MASK);

    always_comb begin
        n_mod = r_mod;
        if (w_take && !w_bad_mod && (i_req.kind == kbrkt_pkg::KIND_MOD_SET)) begin
            if (i_req.value) begin
                n_mod = r_mod | w_bit;
            end else begin
                n_mod = r_mod & ~w_bit;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < kbrkt_pkg::OUT_SLOTS; i++) begin
            w_rep[i] = '0;
        end
        for (int i = 0; i < N && i < kbrkt_pkg::OUT_SLOTS; i++) begin
            w_rep[i] = w_next[i];
        end
    end

    always_comb begin
        n_out.found  = 1'b0;
        n_out.status = w_bad_mod;
        case (i_req.kind)
            kbrkt_pkg::KIND_KEY_QUERY: n_out.found = w_link[N].hit;
            kbrkt_pkg::KIND_MOD_QUERY: n_out.found = !w_bad_mod && |(r_mod & w_bit);
            default:                   n_out.found = 1'b0;
        endcase
        n_out.modifier_byte = n_mod;
        n_out.key_slot0     = w_rep[0];
        n_out.key_slot1     = w_rep[1];
        n_out.key_slot2     = w_rep[2];
        n_out.key_slot3     = w_rep[3];
        n_out.key_slot4     = w_rep[4];
        n_out.key_slot5     = w_rep[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mod   <= n_mod;
            r_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> !o_valid)
        else $error("result without a transaction");

    a_bad_mod_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status |-> !o_result.found && (r_mod == $past(r_mod)))
        else $error("invalid modifier number changed state or reported found");

    a_report_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.modifier_byte == r_mod)
        else $error("reported modifier byte differs from held state");

    for (genvar g = 0; g < N - 1; g++) begin : g_packed_chk
        a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (w_slot[g] == '0) |-> (w_slot[g+1] == '0))
            else $error("key slots not packed to the front");
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_OPS  = 2000;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    kbrkt_pkg::t_req    i_req   = '0;
    logic               o_valid;
    kbrkt_pkg::t_result o_result;

    keyboard_report_key_table_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // shadow copy of the report
    logic [kbrkt_pkg::CODE_W-1:0] key_table [kbrkt_pkg::KEY_SLOTS];
    logic [kbrkt_pkg::CODE_W-1:0] mod_bits;

    kbrkt_pkg::t_req    op_queue[$];
    kbrkt_pkg::t_result report_queue[$];
    int                 total_ops;
    int                 issued_ops;
    int                 error_count;
    int                 cycle_count;

    function automatic logic [kbrkt_pkg::CODE_W-1:0] slot_view(int idx);
        return (idx < kbrkt_pkg::KEY_SLOTS) ? key_table[idx] : '0;
    endfunction

    function automatic kbrkt_pkg::t_result apply_report_op(kbrkt_pkg::t_req op);
        kbrkt_pkg::t_result           r;
        logic [kbrkt_pkg::CODE_W-1:0] bitm;
        logic                         placed;
        int                           hit;
        r      = '0;
        placed = 1'b0;
        hit    = -1;
        case (op.kind)
            kbrkt_pkg::KIND_KEY_QUERY: begin
                for (int i = 0; i < kbrkt_pkg::KEY_SLOTS; i++)
                    if (key_table[i] == op.code) r.found = 1'b1;
            end
            kbrkt_pkg::KIND_KEY_SET: begin
                if (op.value) begin
                    for (int i = 0; i < kbrkt_pkg::KEY_SLOTS; i++) begin
                        if (!placed) begin
                            if (key_table[i] == '0) begin
                                key_table[i] = op.code;
                                placed = 1'b1;
                            end else if (key_table[i] == op.code) begin
                                placed = 1'b1;
                            end
                        end
                    end
                end else begin
                    for (int i = 0; i < kbrkt_pkg::KEY_SLOTS; i++)
                        if (hit < 0 && key_table[i] == op.code) hit = i;
                    if (hit >= 0) begin
                        for (int i = hit; i < kbrkt_pkg::KEY_SLOTS - 1; i++)
                            key_table[i] = key_table[i + 1];
                        key_table[kbrkt_pkg::KEY_SLOTS - 1] = '0;
                    end
                end
            end
            default: begin
                if (op.code > kbrkt_pkg::MOD_MAX) begin
                    r.status = 1'b1;
                end else begin
                    bitm = 8'd1 << op.code[2:0];
                    if (op.kind == kbrkt_pkg::KIND_MOD_QUERY)
                        r.found = |(mod_bits & bitm);
                    else if (op.value)
                        mod_bits = mod_bits | bitm;
                    else
                        mod_bits = mod_bits & ~bitm;
                end
            end
        endcase
        r.modifier_byte = mod_bits;
        r.key_slot0     = slot_view(0);
        r.key_slot1     = slot_view(1);
        r.key_slot2     = slot_view(2);
        r.key_slot3     = slot_view(3);
        r.key_slot4     = slot_view(4);
        r.key_slot5     = slot_view(5);
        return r;
    endfunction

    task automatic add_op(kbrkt_pkg::t_kind kind, int code, bit value);
        kbrkt_pkg::t_req op;
        op.kind  = kind;
        op.code  = code[kbrkt_pkg::CODE_W-1:0];
        op.value = value;
        op_queue.push_back(op);
    endtask

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // driver: one transaction per accepted start
    always @(posedge i_clk) begin : drv
        int idle_pct;
        if (start && !busy) begin
            report_queue.push_back(apply_report_op(op_queue.pop_front()));
            issued_ops++;
        end
        if (issued_ops < total_ops / 3)
            idle_pct = 29;
        else if (issued_ops < 2 * total_ops / 3)
            idle_pct = 87;
        else
            idle_pct = 0;
        if (i_rst_n && op_queue.size() > 0 &&
            ((start && busy) || $urandom_range(0, 99) >= idle_pct)) begin
            start <= 1'b1;
            i_req <= op_queue[0];
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: results cannot be held off, check each strobe
    always @(posedge i_clk) begin : mon
        kbrkt_pkg::t_result                    want;
        logic [kbrkt_pkg::OUT_SLOTS-1:0][7:0]  got_s;
        logic [kbrkt_pkg::OUT_SLOTS-1:0][7:0]  want_s;
        string                                 diff;
        if (o_valid === 1'b1) begin
            if (report_queue.size() == 0) begin
                note_error($sformatf("unexpected transaction %p", o_result));
            end else begin
                want   = report_queue.pop_front();
                diff   = "";
                got_s  = {o_result.key_slot0, o_result.key_slot1, o_result.key_slot2,
                          o_result.key_slot3, o_result.key_slot4, o_result.key_slot5};
                want_s = {want.key_slot0, want.key_slot1, want.key_slot2,
                          want.key_slot3, want.key_slot4, want.key_slot5};
                if (o_result.found !== want.found)
                    diff = {diff, $sformatf(" found exp %0d got %0d",
                                            want.found, o_result.found)};
                if (o_result.status !== want.status)
                    diff = {diff, $sformatf(" status exp %0d got %0d",
                                            want.status, o_result.status)};
                if (o_result.modifier_byte !== want.modifier_byte)
                    diff = {diff, $sformatf(" modifier exp %02h got %02h",
                                            want.modifier_byte, o_result.modifier_byte)};
                for (int i = 0; i < kbrkt_pkg::OUT_SLOTS; i++)
                    if (got_s[kbrkt_pkg::OUT_SLOTS-1-i] !== want_s[kbrkt_pkg::OUT_SLOTS-1-i])
                        diff = {diff, $sformatf(" slot%0d exp %02h got %02h", i,
                                                want_s[kbrkt_pkg::OUT_SLOTS-1-i],
                                                got_s[kbrkt_pkg::OUT_SLOTS-1-i])};
                if (diff != "")
                    note_error({"result mismatch:", diff});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stim
        int               roll;
        int               code;
        kbrkt_pkg::t_kind kind;
        for (int i = 0; i < kbrkt_pkg::KEY_SLOTS; i++) key_table[i] = '0;
        mod_bits    = '0;
        issued_ops  = 0;
        error_count = 0;
        cycle_count = 0;

        // empty table, value ignored on queries, zero code
        add_op(kbrkt_pkg::KIND_KEY_QUERY, 0, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_QUERY, 255, 1'b0);
        add_op(kbrkt_pkg::KIND_MOD_QUERY, 0, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 0, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 4, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 4, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 5, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 6, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 255, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 7, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_SET, 8, 1'b1);
        // full table
        add_op(kbrkt_pkg::KIND_KEY_SET, 9, 1'b1);
        add_op(kbrkt_pkg::KIND_KEY_QUERY, 0, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_QUERY, 255, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 0, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 6, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 6, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 0, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 4, 1'b0);
        add_op(kbrkt_pkg::KIND_KEY_SET, 8, 1'b0);
        // modifier byte, including out-of-range bit numbers
        add_op(kbrkt_pkg::KIND_MOD_SET, 0, 1'b1);
        add_op(kbrkt_pkg::KIND_MOD_SET, 7, 1'b1);
        add_op(kbrkt_pkg::KIND_MOD_SET, 8, 1'b1);
        add_op(kbrkt_pkg::KIND_MOD_SET, 255, 1'b0);
        add_op(kbrkt_pkg::KIND_MOD_QUERY, 7, 1'b0);
        add_op(kbrkt_pkg::KIND_MOD_QUERY, 128, 1'b1);
        add_op(kbrkt_pkg::KIND_MOD_SET, 7, 1'b0);

        // mostly a small code pool so the table fills, hits and shifts
        for (int n = 0; n < RANDOM_OPS; n++) begin
            kind = kbrkt_pkg::t_kind'($urandom_range(0, 3));
            roll = $urandom_range(0, 99);
            if (kind == kbrkt_pkg::KIND_KEY_QUERY || kind == kbrkt_pkg::KIND_KEY_SET)
                code = (roll < 85) ? $urandom_range(1, 10) : $urandom_range(0, 255);
            else
                code = (roll < 85) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            add_op(kind, code, 1'($urandom_range(0, 1)));
        end
        total_ops = op_queue.size();

        while (op_queue.size() > 0 || report_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0 && report_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
